>>> rtl/peer_liveness_table_aging_macros.svh
// Assertion macros shared by the peer liveness table RTL.
`ifndef PEER_LIVENESS_TABLE_AGING_MACROS_SVH
`define PEER_LIVENESS_TABLE_AGING_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define PLTA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("plta assertion failed");

// Next-cycle implication, checked out of reset.
`define PLTA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plta assertion failed");

`endif

>>> rtl/plta_pkg.sv
// Types and constants for the peer liveness table.
package plta_pkg;

  // Input beat: one heard message
  typedef struct packed {
    logic [15:0] src_port;
    logic [31:0] now_ms;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic [1:0]  event_kind;
    logic [15:0] event_port;
    logic [4:0]  live_count;
    logic        any_change;
    logic        last;
  } out_item_t;

  // Event kinds
  localparam logic [1:0] KIND_EXPIRED = 2'd0;
  localparam logic [1:0] KIND_NEW     = 2'd1;
  localparam logic [1:0] KIND_DROPPED = 2'd2;
  localparam logic [1:0] KIND_DONE    = 2'd3;

  localparam int          TTL_W     = 31;
  localparam logic [30:0] TTL_RESET = 31'd5000;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_INSERT,
    ST_DONE
  } plta_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic sweep;
    logic insert;
    logic finish;
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic sweep_last;
  } dp_stat_t;

endpackage

>>> rtl/peer_liveness_table_aging.sv
// Peer liveness table with TTL aging: top level.
//
// Usage: present a heard message (sender port, ms timestamp) on in_data and
// raise start while busy is low; that edge takes the beat. The block then
// walks every slot once, refreshing a matching entry and expiring stale ones
// (one expired beat per expiry, in slot order), then, if no entry matched,
// inserts the port or reports it dropped, and ends with a done beat
// (last = 1) carrying the live count and a change flag. Each result beat
// is on out_data for one cycle with out_strobe high; the receiver cannot
// stall it.
// Sequence: busy stays high through the sweep (one slot per cycle over the
// slot memories, which have one write port each and a registered read), then
// insert, then done; the done beat is on the outputs in the cycle busy falls,
// and the next message can be taken in that same cycle.
// Configuration: the cfg channel writes the 31-bit TTL; cfg_ready is always
// high. Write it only while busy is low.
// Reset: rst_n (synchronous) empties the table and sets the TTL to 5000 ms.
module peer_liveness_table_aging #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  plta_pkg::in_item_t  in_data,
  output logic                out_strobe,
  output plta_pkg::out_item_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [30:0]         cfg_data
);
  import plta_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  plta_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  plta_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

endmodule

>>> rtl/plta_ctrl.sv
// Sequencer for the peer liveness table: accept, sweep, insert, done.
`include "peer_liveness_table_aging_macros.svh"
module plta_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  plta_pkg::dp_stat_t  stat,
  output plta_pkg::ctrl_cmd_t cmd
);
  import plta_pkg::*;

  plta_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) state_nxt = ST_INSERT;
      end
      ST_INSERT: begin
        cmd.insert = 1'b1;
        state_nxt  = ST_DONE;
      end
      ST_DONE: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // One item runs sweep, insert and done before the next is taken
  `PLTA_ASSERT_NXT(a_accept_sweeps, clk, rst_n, start && !busy, state_r == ST_SWEEP)
  `PLTA_ASSERT_NXT(a_insert_done, clk, rst_n, state_r == ST_INSERT, state_r == ST_DONE)
  `PLTA_ASSERT_NXT(a_done_idle, clk, rst_n, cmd.finish, !busy)

endmodule

>>> rtl/plta_dp.sv
// Datapath: slot tables, sweep compare, live count, TTL register, result register.
`include "peer_liveness_table_aging_macros.svh"
module plta_dp #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  plta_pkg::ctrl_cmd_t   cmd,
  output plta_pkg::dp_stat_t    stat,
  input  plta_pkg::in_item_t    in_data,
  output logic                  out_strobe,
  output plta_pkg::out_item_t   out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [30:0]           cfg_data
);
  import plta_pkg::*;

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // Masks a live count to the 5-bit result field
  function automatic logic [4:0] to_live(input logic [CNT_W-1:0] c);
    logic [CNT_W+4:0] w;
    w = {5'd0, c};
    return w[4:0];
  endfunction

  // Slot tables: valid bits in flops, port and seen time in memories
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [15:0]              mem_port [TABLE_ENTRIES];
  logic [31:0]              mem_time [TABLE_ENTRIES];
  logic [15:0]              rd_port_r;
  logic [31:0]              rd_time_r;
  logic [IDX_W-1:0]         rd_addr;

  // Per-item state
  logic [IDX_W-1:0] idx_r, free_idx_r;
  logic [15:0]      port_r;
  logic [31:0]      now_r;
  logic             matched_r, changed_r, free_found_r, all_exp_r;
  logic [CNT_W-1:0] cnt_r;
  logic [30:0]      ttl_r;

  // Result register
  logic      out_strobe_r;
  out_item_t out_data_r;

  // Sweep compare
  logic        cur_valid, hit, expire, ins_ok;
  logic [31:0] age;
  logic [CNT_W-1:0] cnt_dec, cnt_inc;

  assign cur_valid = valid_r[idx_r];
  assign hit       = cur_valid && (rd_port_r == port_r);
  assign age       = now_r - rd_time_r;
  assign expire    = cur_valid && !hit && (age > {1'b0, ttl_r});
  assign cnt_dec   = cnt_r - 1'b1;
  assign cnt_inc   = cnt_r + 1'b1;
  assign ins_ok    = cmd.insert && !matched_r && free_found_r;

  assign stat.sweep_last = (idx_r == LAST_IDX);

  // Read the next slot while comparing this one; slot 0 is prefetched when idle
  always_comb begin
    if (cmd.sweep) begin
      rd_addr = (idx_r == LAST_IDX) ? idx_r : idx_r + 1'b1;
    end else begin
      rd_addr = '0;
    end
  end

  // Memories: one write port each, registered read
  always_ff @(posedge clk) begin
    rd_port_r <= mem_port[rd_addr];
    rd_time_r <= mem_time[rd_addr];
    if (ins_ok) begin
      mem_port[free_idx_r] <= port_r;
    end
    if (cmd.sweep && hit) begin
      mem_time[idx_r] <= now_r;
    end else if (ins_ok) begin
      mem_time[free_idx_r] <= now_r;
    end
  end

  // TTL register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_r <= TTL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      ttl_r <= cfg_data;
    end
  end

  // Control state: valid bits, live count, sweep flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r      <= '0;
      cnt_r        <= '0;
      idx_r        <= '0;
      matched_r    <= 1'b0;
      changed_r    <= 1'b0;
      free_found_r <= 1'b0;
      all_exp_r    <= 1'b0;
    end else begin
      priority if (cmd.load) begin
        idx_r        <= '0;
        matched_r    <= 1'b0;
        changed_r    <= 1'b0;
        free_found_r <= 1'b0;
        all_exp_r    <= 1'b1;
      end else if (cmd.sweep) begin
        if (idx_r != LAST_IDX) idx_r <= idx_r + 1'b1;
        if (hit) matched_r <= 1'b1;
        if (expire) begin
          valid_r[idx_r] <= 1'b0;
          cnt_r          <= cnt_dec;
          changed_r      <= 1'b1;
        end else begin
          all_exp_r <= 1'b0;
        end
        if (!free_found_r && (!cur_valid || expire)) free_found_r <= 1'b1;
      end else if (ins_ok) begin
        valid_r[free_idx_r] <= 1'b1;
        cnt_r               <= cnt_inc;
        changed_r           <= 1'b1;
      end else if (cmd.finish) begin
        idx_r <= '0;
      end else begin
        idx_r <= idx_r;
      end
    end
  end

  // Lowest free slot of the sweep
  always_ff @(posedge clk) begin
    if (cmd.sweep && !free_found_r && (!cur_valid || expire)) begin
      free_idx_r <= idx_r;
    end
  end

  // Input beat capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      port_r <= in_data.src_port;
      now_r  <= in_data.now_ms;
    end
  end

  // Result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= (cmd.sweep && expire) || cmd.finish ||
                      (cmd.insert && !matched_r && (!free_found_r || !all_exp_r));
    end
  end

  always_ff @(posedge clk) begin
    out_data_r.any_change <= 1'b0;
    out_data_r.last       <= 1'b0;
    priority if (cmd.sweep) begin
      out_data_r.event_kind <= KIND_EXPIRED;
      out_data_r.event_port <= rd_port_r;
      out_data_r.live_count <= to_live(cnt_dec);
    end else if (cmd.insert) begin
      out_data_r.event_port <= port_r;
      if (free_found_r) begin
        out_data_r.event_kind <= KIND_NEW;
        out_data_r.live_count <= to_live(cnt_inc);
      end else begin
        out_data_r.event_kind <= KIND_DROPPED;
        out_data_r.live_count <= to_live(cnt_r);
      end
    end else begin
      out_data_r.event_kind <= KIND_DONE;
      out_data_r.event_port <= port_r;
      out_data_r.live_count <= to_live(cnt_r);
      out_data_r.any_change <= changed_r;
      out_data_r.last       <= 1'b1;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  `PLTA_ASSERT_IMP(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CNT_W'(TABLE_ENTRIES))
  `PLTA_ASSERT_NXT(a_insert_valid, clk, rst_n, ins_ok, valid_r[$past(free_idx_r)])
  `PLTA_ASSERT_NXT(a_hit_stays, clk, rst_n, cmd.sweep && hit, valid_r[$past(idx_r)])

endmodule
